// ===== hw/rtl/bresenham_line_raster_defines.svh =====
// Assertion macros for the line rasterizer
`ifndef BRESENHAM_LINE_RASTER_DEFINES_SVH
`define BRESENHAM_LINE_RASTER_DEFINES_SVH

`ifndef SYNTHESIS
`define BLR_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("bresenham_line_raster assertion failed");
`define BLR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	`BLR_ASSERT(label, clk, rst_n, (ante) |-> (cons))
`define BLR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	`BLR_ASSERT(label, clk, rst_n, (ante) |=> (cons))
`else
`define BLR_ASSERT(label, clk, rst_n, prop)
`define BLR_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define BLR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/blr_pkg.sv =====
// Shared types and codes of the line rasterizer
`default_nettype none

package blr_pkg;

	localparam int unsigned COLOUR_BITS = 16;

	typedef logic [COLOUR_BITS-1:0] colour_t;

	// command codes carried in the action field
	typedef enum logic {
		ACT_START   = 1'b0,
		ACT_ADVANCE = 1'b1
	} action_t;

endpackage

`default_nettype wire

// ===== hw/rtl/blr_if.sv =====
// Command and pixel channel interfaces of the line rasterizer
`default_nettype none

interface blr_cmd_if #(
	parameter int unsigned COORD_BITS = 8
);
	import blr_pkg::*;

	logic                  valid;
	logic                  ready;
	action_t               action;
	logic [COORD_BITS-1:0] start_x;
	logic [COORD_BITS-1:0] start_y;
	logic [COORD_BITS-1:0] end_x;
	logic [COORD_BITS-1:0] end_y;
	colour_t               colour;

	modport source (
		output valid, action, start_x, start_y, end_x, end_y, colour,
		input  ready
	);
	modport sink (
		input  valid, action, start_x, start_y, end_x, end_y, colour,
		output ready
	);
endinterface

interface blr_pix_if #(
	parameter int unsigned COORD_BITS = 8
);
	import blr_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;
	colour_t               pixel_colour;
	logic                  last_pixel;

	modport source (
		output valid, pixel_x, pixel_y, pixel_colour, last_pixel,
		input  ready
	);
	modport sink (
		input  valid, pixel_x, pixel_y, pixel_colour, last_pixel,
		output ready
	);
endinterface

`default_nettype wire

// ===== hw/rtl/bresenham_line_raster.sv =====
// Top level of the Bresenham line rasterizer
// A pixel appears on the pix channel in the cycle after its cmd beat is accepted.
// Throughput: one cmd beat and one pixel per cycle while the pix channel takes the pixels; the step loop is a single
// register stage (error add/compare and cursor increment) closing on itself.
// A start beat emits the first pixel; each advance beat on a live line emits the next one.
// Reset (arst_n low, asynchronous) drops any line in progress and empties the output register.
`default_nettype none

module bresenham_line_raster #(
	parameter int unsigned COORD_BITS = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	blr_cmd_if.sink  cmd,
	blr_pix_if.source pix
);
	import blr_pkg::*;

	`include "bresenham_line_raster_defines.svh"

	localparam int unsigned CW = COORD_BITS;
	localparam int unsigned EW = COORD_BITS + 3;

	// line state
	logic                 line_active_q;
	logic [CW-1:0]        cursor_x_q;
	logic [CW-1:0]        cursor_y_q;
	logic signed [EW-1:0] error_term_q;
	logic [CW:0]          pixels_left_q;
	logic                 x_decrements_q;
	logic                 y_decrements_q;
	logic                 x_is_major_q;
	logic [CW:0]          major_delta_twice_q;
	logic [CW:0]          minor_delta_twice_q;
	colour_t              line_colour_q;

	// output register
	logic                 res_valid_q;
	logic [CW-1:0]        res_x_q;
	logic [CW-1:0]        res_y_q;
	colour_t              res_colour_q;
	logic                 res_last_q;

	// setup results for a start beat
	logic                 su_x_dec;
	logic                 su_y_dec;
	logic                 su_x_major;
	logic [CW:0]          su_maj2;
	logic [CW:0]          su_min2;
	logic signed [EW-1:0] su_err;
	logic [CW:0]          su_count;

	// operands of the step: fresh setup on start, stored line otherwise
	logic                 is_start;
	logic                 cmd_fire;
	logic                 emit;
	logic [CW-1:0]        op_x;
	logic [CW-1:0]        op_y;
	logic signed [EW-1:0] op_err;
	logic [CW:0]          op_count;
	logic                 op_x_dec;
	logic                 op_y_dec;
	logic                 op_x_major;
	logic [CW:0]          op_maj2;
	logic [CW:0]          op_min2;
	colour_t              op_colour;

	// step results
	logic                 err_nonneg;
	logic signed [EW-1:0] err_after_minor;
	logic signed [EW-1:0] nxt_err;
	logic                 step_x;
	logic                 step_y;
	logic [CW-1:0]        nxt_x;
	logic [CW-1:0]        nxt_y;
	logic [CW:0]          nxt_count;
	logic                 last;

	blr_setup #(
		.COORD_BITS(COORD_BITS)
	) u_setup (
		.start_x          (cmd.start_x),
		.start_y          (cmd.start_y),
		.end_x            (cmd.end_x),
		.end_y            (cmd.end_y),
		.x_decrements     (su_x_dec),
		.y_decrements     (su_y_dec),
		.x_is_major       (su_x_major),
		.major_delta_twice(su_maj2),
		.minor_delta_twice(su_min2),
		.error_init       (su_err),
		.pixels_init      (su_count)
	);

	// the output register frees up in the same cycle its pixel is taken
	assign cmd.ready = !res_valid_q || pix.ready;
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign is_start  = cmd.action == ACT_START;
	// an advance while idle is swallowed without a pixel
	assign emit      = cmd_fire && (is_start || line_active_q);

	always_comb begin
		if (is_start) begin
			op_x       = cmd.start_x;
			op_y       = cmd.start_y;
			op_err     = su_err;
			op_count   = su_count;
			op_x_dec   = su_x_dec;
			op_y_dec   = su_y_dec;
			op_x_major = su_x_major;
			op_maj2    = su_maj2;
			op_min2    = su_min2;
			op_colour  = cmd.colour;
		end else begin
			op_x       = cursor_x_q;
			op_y       = cursor_y_q;
			op_err     = error_term_q;
			op_count   = pixels_left_q;
			op_x_dec   = x_decrements_q;
			op_y_dec   = y_decrements_q;
			op_x_major = x_is_major_q;
			op_maj2    = major_delta_twice_q;
			op_min2    = minor_delta_twice_q;
			op_colour  = line_colour_q;
		end
	end

	always_comb begin
		// non-negative error: pay back one major span and move the minor axis too
		err_nonneg      = !op_err[EW-1];
		err_after_minor = err_nonneg ? (op_err - $signed({2'b00, op_maj2})) : op_err;
		nxt_err         = err_after_minor + $signed({2'b00, op_min2});
		step_x          = op_x_major || err_nonneg;
		step_y          = !op_x_major || err_nonneg;
		nxt_x           = step_x ? (op_x_dec ? op_x - 1'b1 : op_x + 1'b1) : op_x;
		nxt_y           = step_y ? (op_y_dec ? op_y - 1'b1 : op_y + 1'b1) : op_y;
		nxt_count       = (op_count != '0) ? op_count - 1'b1 : op_count;
		last            = nxt_count == '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_active_q       <= 1'b0;
			cursor_x_q          <= '0;
			cursor_y_q          <= '0;
			error_term_q        <= '0;
			pixels_left_q       <= '0;
			x_decrements_q      <= 1'b0;
			y_decrements_q      <= 1'b0;
			x_is_major_q        <= 1'b0;
			major_delta_twice_q <= '0;
			minor_delta_twice_q <= '0;
			line_colour_q       <= '0;
		end else if (emit) begin
			line_active_q       <= !last;
			cursor_x_q          <= nxt_x;
			cursor_y_q          <= nxt_y;
			error_term_q        <= nxt_err;
			pixels_left_q       <= nxt_count;
			x_decrements_q      <= op_x_dec;
			y_decrements_q      <= op_y_dec;
			x_is_major_q        <= op_x_major;
			major_delta_twice_q <= op_maj2;
			minor_delta_twice_q <= op_min2;
			line_colour_q       <= op_colour;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (pix.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// pixel payload: the cursor before this step
	always_ff @(posedge clk) begin
		if (emit) begin
			res_x_q      <= op_x;
			res_y_q      <= op_y;
			res_colour_q <= op_colour;
			res_last_q   <= last;
		end
	end

	assign pix.valid        = res_valid_q;
	assign pix.pixel_x      = res_x_q;
	assign pix.pixel_y      = res_y_q;
	assign pix.pixel_colour = res_colour_q;
	assign pix.last_pixel   = res_last_q;

	// a line is live exactly while pixels remain
	`BLR_ASSERT(a_active_count, clk, arst_n, line_active_q == (pixels_left_q != '0))
	// the major span never falls below the minor one
	`BLR_ASSERT(a_major_ge_minor, clk, arst_n, major_delta_twice_q >= minor_delta_twice_q)
	// a start, or an advance on a live line, always yields a pixel
	`BLR_ASSERT_NEXT(a_emit_pixel, clk, arst_n,
		cmd.valid && cmd.ready && (cmd.action == ACT_START || line_active_q), pix.valid)
	// an advance while idle yields nothing once the old pixel has drained
	`BLR_ASSERT_NEXT(a_idle_silent, clk, arst_n,
		cmd.valid && cmd.ready && cmd.action == ACT_ADVANCE && !line_active_q && pix.ready,
		!pix.valid)

endmodule

`default_nettype wire

// ===== hw/rtl/blr_setup.sv =====
// Line setup: directions, major axis, doubled deltas, initial error and pixel count
`default_nettype none

module blr_setup #(
	parameter int unsigned COORD_BITS = 8
) (
	input  wire logic [COORD_BITS-1:0]        start_x,
	input  wire logic [COORD_BITS-1:0]        start_y,
	input  wire logic [COORD_BITS-1:0]        end_x,
	input  wire logic [COORD_BITS-1:0]        end_y,
	output      logic                         x_decrements,
	output      logic                         y_decrements,
	output      logic                         x_is_major,
	output      logic [COORD_BITS:0]          major_delta_twice,
	output      logic [COORD_BITS:0]          minor_delta_twice,
	output      logic signed [COORD_BITS+2:0] error_init,
	output      logic [COORD_BITS:0]          pixels_init
);

	logic [COORD_BITS-1:0] adx;
	logic [COORD_BITS-1:0] ady;
	logic [COORD_BITS-1:0] major;
	logic [COORD_BITS-1:0] minor;

	always_comb begin
		x_decrements = end_x < start_x;
		y_decrements = end_y < start_y;
		adx = x_decrements ? (start_x - end_x) : (end_x - start_x);
		ady = y_decrements ? (start_y - end_y) : (end_y - start_y);
		// ties step along y
		x_is_major = adx > ady;
		major = x_is_major ? adx : ady;
		minor = x_is_major ? ady : adx;
		major_delta_twice = {major, 1'b0};
		minor_delta_twice = {minor, 1'b0};
		error_init = $signed({2'b00, minor_delta_twice}) - $signed({3'b000, major});
		pixels_init = {1'b0, major} + {{COORD_BITS{1'b0}}, 1'b1};
	end

endmodule

`default_nettype wire
